// ----- hdl/uartrb_pkg.sv -----
`timescale 1ns / 1ps

package uartrb_pkg;

  localparam int RX_DEPTH = 128;
  localparam int TX_DEPTH = 128;

  // pointers run modulo twice the depth so that full and empty differ
  localparam int RX_PW = $clog2(2 * RX_DEPTH);
  localparam int TX_PW = $clog2(2 * TX_DEPTH);
  localparam int RX_AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int TX_AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;

  typedef logic [RX_PW-1:0] rx_ptr_t;
  typedef logic [TX_PW-1:0] tx_ptr_t;
  typedef logic [RX_AW-1:0] rx_addr_t;
  typedef logic [TX_AW-1:0] tx_addr_t;

  localparam rx_ptr_t RX_PTR_LAST = rx_ptr_t'(2 * RX_DEPTH - 1);
  localparam tx_ptr_t TX_PTR_LAST = tx_ptr_t'(2 * TX_DEPTH - 1);
  localparam rx_ptr_t RX_PTR_DEPTH = rx_ptr_t'(RX_DEPTH);
  localparam tx_ptr_t TX_PTR_DEPTH = tx_ptr_t'(TX_DEPTH);

  typedef enum logic [1:0] {
    KIND_LINE_BYTE  = 2'd0,
    KIND_TX_READY   = 2'd1,
    KIND_HOST_READ  = 2'd2,
    KIND_HOST_WRITE = 2'd3
  } kind_t;

  function automatic rx_ptr_t rx_ptr_next(rx_ptr_t p);
    return (p == RX_PTR_LAST) ? '0 : rx_ptr_t'(p + 1'b1);
  endfunction

  function automatic tx_ptr_t tx_ptr_next(tx_ptr_t p);
    return (p == TX_PTR_LAST) ? '0 : tx_ptr_t'(p + 1'b1);
  endfunction

  function automatic rx_addr_t rx_slot(rx_ptr_t p);
    return (p >= RX_PTR_DEPTH) ? rx_addr_t'(p - RX_PTR_DEPTH) : rx_addr_t'(p);
  endfunction

  function automatic tx_addr_t tx_slot(tx_ptr_t p);
    return (p >= TX_PTR_DEPTH) ? tx_addr_t'(p - TX_PTR_DEPTH) : tx_addr_t'(p);
  endfunction

  function automatic rx_ptr_t rx_count(rx_ptr_t h, rx_ptr_t t);
    return (h >= t) ? rx_ptr_t'(h - t)
                    : rx_ptr_t'(32'(2 * RX_DEPTH) - 32'(t) + 32'(h));
  endfunction

  function automatic tx_ptr_t tx_count(tx_ptr_t h, tx_ptr_t t);
    return (h >= t) ? tx_ptr_t'(h - t)
                    : tx_ptr_t'(32'(2 * TX_DEPTH) - 32'(t) + 32'(h));
  endfunction

endpackage

// ----- hdl/uartrb_ram.sv -----
`timescale 1ns / 1ps

module uartrb_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 8
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/uart_rx_tx_ring_buffers_core.sv -----
`timescale 1ns / 1ps

// Line byte or host write: result presented in the cycle after the transaction.
// Popping host read or transmitter-ready: memory read register, then output register;
// input stalls until then. Otherwise 1 transaction per cycle while out_stall is low.
// Reset (rst, synchronous): ring pointers, full flag and transmitter service cleared.
// Ring memories are not cleared; no entry is read before it has been written.
module uart_rx_tx_ring_buffers_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] kind,
  input  logic [7:0] data,
  input  logic       line_error,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] read_data,
  output logic       read_empty,
  output logic       tx_valid,
  output logic [7:0] tx_data,
  output logic       rx_dropped,
  output logic       tx_refused,
  output logic [7:0] rx_count,
  output logic [7:0] tx_free,
  output logic       tx_idle
);

  import uartrb_pkg::*;

  rx_ptr_t rx_head, rx_tail, rx_head_next, rx_tail_next;
  tx_ptr_t tx_head, tx_tail, tx_head_next, tx_tail_next;
  logic    tx_full_flag, tx_full_flag_next;
  logic    tx_active, tx_active_next;

  logic    pending, pend_rx_pop, pend_tx_pop;

  rx_ptr_t rxc, rxc_next;
  tx_ptr_t txc, txc_next;
  logic    accept;
  logic    rx_we, tx_we, rx_pop, tx_pop;
  logic    empty_c, dropped_c, refused_c;
  logic [31:0] rx_cnt_w, tx_free_w;
  logic [7:0]  rx_rdata, tx_rdata;

  assign in_stall = pending || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  assign rxc = uartrb_pkg::rx_count(rx_head, rx_tail);
  assign txc = tx_count(tx_head, tx_tail);

  always_comb begin
    rx_head_next      = rx_head;
    rx_tail_next      = rx_tail;
    tx_head_next      = tx_head;
    tx_tail_next      = tx_tail;
    tx_full_flag_next = tx_full_flag;
    tx_active_next    = tx_active;
    rx_we     = 1'b0;
    tx_we     = 1'b0;
    rx_pop    = 1'b0;
    tx_pop    = 1'b0;
    empty_c   = 1'b0;
    dropped_c = 1'b0;
    refused_c = 1'b0;
    unique case (kind_t'(kind))
      KIND_LINE_BYTE: begin
        if (line_error || rxc == RX_PTR_DEPTH) begin
          dropped_c = 1'b1;
        end else begin
          rx_we        = 1'b1;
          rx_head_next = rx_ptr_next(rx_head);
        end
      end
      KIND_TX_READY: begin
        if (tx_active) begin
          if (txc != '0) begin
            tx_pop            = 1'b1;
            tx_tail_next      = tx_ptr_next(tx_tail);
            tx_full_flag_next = 1'b0;
          end else begin
            tx_active_next = 1'b0;
          end
        end
      end
      KIND_HOST_READ: begin
        if (rxc == '0) begin
          empty_c = 1'b1;
        end else begin
          rx_pop       = 1'b1;
          rx_tail_next = rx_ptr_next(rx_tail);
        end
      end
      KIND_HOST_WRITE: begin
        if (tx_full_flag || txc == TX_PTR_DEPTH) begin
          refused_c = 1'b1;
        end else begin
          tx_we          = 1'b1;
          tx_head_next   = tx_ptr_next(tx_head);
          tx_active_next = 1'b1;
          if (tx_count(tx_head_next, tx_tail) == TX_PTR_DEPTH) begin
            tx_full_flag_next = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign rxc_next  = uartrb_pkg::rx_count(rx_head_next, rx_tail_next);
  assign txc_next  = tx_count(tx_head_next, tx_tail_next);
  assign rx_cnt_w  = 32'(rxc_next);
  assign tx_free_w = 32'(TX_DEPTH) - 32'(txc_next);

  // read port follows the tail; data for a pop is ready the cycle after the transaction
  uartrb_ram #(.DEPTH(RX_DEPTH), .WIDTH(8)) u_rx_ram (
    .clk   (clk),
    .we    (accept && rx_we),
    .waddr (rx_slot(rx_head)),
    .wdata (data),
    .raddr (rx_slot(rx_tail)),
    .rdata (rx_rdata)
  );

  uartrb_ram #(.DEPTH(TX_DEPTH), .WIDTH(8)) u_tx_ram (
    .clk   (clk),
    .we    (accept && tx_we),
    .waddr (tx_slot(tx_head)),
    .wdata (data),
    .raddr (tx_slot(tx_tail)),
    .rdata (tx_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_head      <= '0;
      rx_tail      <= '0;
      tx_head      <= '0;
      tx_tail      <= '0;
      tx_full_flag <= 1'b0;
      tx_active    <= 1'b0;
      pending      <= 1'b0;
      pend_rx_pop  <= 1'b0;
      pend_tx_pop  <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      // accept implies no pending pop and no held result
      out_valid <= (out_valid && out_stall) || pending || (accept && !(rx_pop || tx_pop));
      pending   <= accept && (rx_pop || tx_pop);
      if (pending) begin
        read_data <= pend_rx_pop ? rx_rdata : 8'h00;
        tx_data   <= pend_tx_pop ? tx_rdata : 8'h00;
      end
      if (accept) begin
        rx_head      <= rx_head_next;
        rx_tail      <= rx_tail_next;
        tx_head      <= tx_head_next;
        tx_tail      <= tx_tail_next;
        tx_full_flag <= tx_full_flag_next;
        tx_active    <= tx_active_next;
        pend_rx_pop  <= rx_pop;
        pend_tx_pop  <= tx_pop;
        read_empty   <= empty_c;
        tx_valid     <= tx_pop;
        rx_dropped   <= dropped_c;
        tx_refused   <= refused_c;
        rx_count     <= rx_cnt_w[7:0];
        tx_free      <= tx_free_w[7:0];
        tx_idle      <= !tx_active_next;
        if (!(rx_pop || tx_pop)) begin
          read_data <= 8'h00;
          tx_data   <= 8'h00;
        end
      end
    end
  end

  a_pop_delivers: assert property (@(posedge clk) disable iff (rst)
    pending |=> out_valid && !pending)
    else $error("pop transaction did not deliver its result");

  a_rx_bound: assert property (@(posedge clk) disable iff (rst)
    rxc <= RX_PTR_DEPTH)
    else $error("receive ring count exceeds depth");

  a_tx_full_flag: assert property (@(posedge clk) disable iff (rst)
    tx_full_flag == (txc == TX_PTR_DEPTH))
    else $error("transmit full flag out of step with pointers");

  a_write_enables: assert property (@(posedge clk) disable iff (rst)
    accept && tx_we |=> tx_active && tx_head != $past(tx_head))
    else $error("accepted host write did not advance transmit ring");

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import uartrb_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;
  localparam int RX_WRAP     = 2 * RX_DEPTH;
  localparam int TX_WRAP     = 2 * TX_DEPTH;

  typedef struct {
    logic [7:0] read_data;
    logic       read_empty;
    logic       tx_valid;
    logic [7:0] tx_data;
    logic       rx_dropped;
    logic       tx_refused;
    logic [7:0] rx_count;
    logic [7:0] tx_free;
    logic       tx_idle;
  } ring_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] kind = 2'd0;
  logic [7:0] data = 8'd0;
  logic       line_error = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] read_data;
  logic       read_empty;
  logic       tx_valid;
  logic [7:0] tx_data;
  logic       rx_dropped;
  logic       tx_refused;
  logic [7:0] rx_count;
  logic [7:0] tx_free;
  logic       tx_idle;

  uart_rx_tx_ring_buffers_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .data      (data),
    .line_error(line_error),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .read_data (read_data),
    .read_empty(read_empty),
    .tx_valid  (tx_valid),
    .tx_data   (tx_data),
    .rx_dropped(rx_dropped),
    .tx_refused(tx_refused),
    .rx_count  (rx_count),
    .tx_free   (tx_free),
    .tx_idle   (tx_idle)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state: pointers run modulo twice the depth
  logic [7:0] rx_mem [RX_DEPTH];
  logic [7:0] tx_mem [TX_DEPTH];
  int         rx_wr = 0, rx_rd = 0, tx_wr = 0, tx_rd = 0;
  bit         tx_full_seen = 1'b0;
  bit         tx_service_on = 1'b0;

  ring_result_t awaited_results [$];
  int  mismatch_count = 0;
  int  cycle_count = 0;
  int  snd_idle_pct = 0;
  int  rcv_idle_pct = 0;
  logic hold_on = 1'b0;
  event hold_go;

  function automatic int ring_fill(int head, int tail, int wrap);
    return (head - tail + wrap) % wrap;
  endfunction

  function automatic ring_result_t predict_ring_step(kind_t k, logic [7:0] d, logic err);
    ring_result_t r;
    int rxc, txc;
    r = '{default: '0};
    rxc = ring_fill(rx_wr, rx_rd, RX_WRAP);
    txc = ring_fill(tx_wr, tx_rd, TX_WRAP);
    case (k)
      KIND_LINE_BYTE: begin
        if (err || rxc >= RX_DEPTH) begin
          r.rx_dropped = 1'b1;
        end else begin
          rx_mem[rx_addr_t'(rx_wr % RX_DEPTH)] = d;
          rx_wr = (rx_wr + 1) % RX_WRAP;
        end
      end
      KIND_TX_READY: begin
        if (tx_service_on) begin
          if (txc != 0) begin
            r.tx_data  = tx_mem[tx_addr_t'(tx_rd % TX_DEPTH)];
            r.tx_valid = 1'b1;
            tx_rd = (tx_rd + 1) % TX_WRAP;
            tx_full_seen = 1'b0;
          end else begin
            tx_service_on = 1'b0;
          end
        end
      end
      KIND_HOST_READ: begin
        if (rxc == 0) begin
          r.read_empty = 1'b1;
        end else begin
          r.read_data = rx_mem[rx_addr_t'(rx_rd % RX_DEPTH)];
          rx_rd = (rx_rd + 1) % RX_WRAP;
        end
      end
      default: begin
        if (tx_full_seen || txc >= TX_DEPTH) begin
          r.tx_refused = 1'b1;
        end else begin
          tx_mem[tx_addr_t'(tx_wr % TX_DEPTH)] = d;
          tx_wr = (tx_wr + 1) % TX_WRAP;
          tx_service_on = 1'b1;
          if (ring_fill(tx_wr, tx_rd, TX_WRAP) == TX_DEPTH) tx_full_seen = 1'b1;
        end
      end
    endcase
    r.rx_count = 8'(ring_fill(rx_wr, rx_rd, RX_WRAP));
    r.tx_free  = 8'(TX_DEPTH - ring_fill(tx_wr, tx_rd, TX_WRAP));
    r.tx_idle  = !tx_service_on;
    return r;
  endfunction

  function automatic void compare_field(string fname, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch on %s: expected %0d, got %0d", fname, want, got);
    end
  endfunction

  // result checking and receiver stall
  always @(posedge clk) begin : result_check
    ring_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("result transaction with nothing expected");
      end else begin
        want = awaited_results.pop_front();
        compare_field("read_data", want.read_data, read_data);
        compare_field("read_empty", 8'(want.read_empty), 8'(read_empty));
        compare_field("tx_valid", 8'(want.tx_valid), 8'(tx_valid));
        compare_field("tx_data", want.tx_data, tx_data);
        compare_field("rx_dropped", 8'(want.rx_dropped), 8'(rx_dropped));
        compare_field("tx_refused", 8'(want.tx_refused), 8'(tx_refused));
        compare_field("rx_count", want.rx_count, rx_count);
        compare_field("tx_free", want.tx_free, tx_free);
        compare_field("tx_idle", 8'(want.tx_idle), 8'(tx_idle));
      end
    end
    out_stall <= hold_on || ($urandom_range(99) < rcv_idle_pct);
  end

  // long receiver hold-off, counted here
  always @(hold_go) begin
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_event(input kind_t k, input logic [7:0] d, input logic err);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    kind       <= k;
    data       <= d;
    line_error <= err;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    awaited_results.push_back(predict_ring_step(k, d, err));
  endtask

  task automatic set_idling(input int snd_pct, input int rcv_pct);
    snd_idle_pct = snd_pct;
    rcv_idle_pct <= rcv_pct;
  endtask

  task automatic test_directed();
    send_event(KIND_HOST_READ, 8'h00, 1'b0);   // read on empty ring
    send_event(KIND_TX_READY, 8'h00, 1'b0);    // service still off
    send_event(KIND_HOST_WRITE, 8'h00, 1'b0);
    send_event(KIND_HOST_WRITE, 8'hFF, 1'b1);  // error bit ignored on writes
    send_event(KIND_TX_READY, 8'hFF, 1'b1);
    send_event(KIND_TX_READY, 8'h00, 1'b0);
    send_event(KIND_TX_READY, 8'h00, 1'b0);    // empty ring turns service off
    send_event(KIND_TX_READY, 8'h00, 1'b0);
    send_event(KIND_LINE_BYTE, 8'hFF, 1'b1);   // line error drop
    send_event(KIND_LINE_BYTE, 8'h00, 1'b0);
    send_event(KIND_LINE_BYTE, 8'hFF, 1'b0);
    send_event(KIND_LINE_BYTE, 8'hA5, 1'b0);
    send_event(KIND_HOST_READ, 8'hFF, 1'b1);
    send_event(KIND_HOST_READ, 8'h00, 1'b0);
    send_event(KIND_HOST_READ, 8'h5A, 1'b1);
    send_event(KIND_HOST_READ, 8'h00, 1'b0);
    send_event(KIND_TX_READY, 8'hC3, 1'b1);
    send_event(KIND_HOST_WRITE, 8'h5A, 1'b1);
    send_event(KIND_LINE_BYTE, 8'h5A, 1'b0);
    send_event(KIND_HOST_READ, 8'h00, 1'b0);
    send_event(KIND_TX_READY, 8'h00, 1'b0);
  endtask

  task automatic test_rx_overflow();
    repeat (RX_DEPTH + 2) send_event(KIND_LINE_BYTE, 8'($urandom_range(255)), 1'b0);
    repeat (RX_DEPTH + 2) send_event(KIND_HOST_READ, 8'($urandom_range(255)), 1'($urandom));
  endtask

  task automatic test_tx_overflow();
    repeat (TX_DEPTH + 2) send_event(KIND_HOST_WRITE, 8'($urandom_range(255)), 1'($urandom));
    repeat (TX_DEPTH + 3) send_event(KIND_TX_READY, 8'($urandom_range(255)), 1'($urandom));
  endtask

  // windows, most of them biased toward one event kind, push the rings to full and empty
  task automatic test_random_mix(input int count);
    int   sent, span, bias;
    kind_t k;
    sent = 0;
    while (sent < count) begin
      span = $urandom_range(200, 20);
      bias = $urandom_range(4);
      for (int j = 0; j < span && sent < count; j++) begin
        if (bias < 4 && $urandom_range(99) < 70) k = kind_t'(bias);
        else k = kind_t'($urandom_range(3));
        send_event(k, 8'($urandom_range(255)), $urandom_range(7) == 0);
        sent++;
      end
    end
  endtask

  task automatic test_backpressure();
    -> hold_go;
    repeat (150) send_event(kind_t'($urandom_range(3)), 8'($urandom_range(255)), 1'($urandom));
  endtask

  initial begin
    for (int i = 0; i < RX_DEPTH; i++) rx_mem[rx_addr_t'(i)] = '0;
    for (int i = 0; i < TX_DEPTH; i++) tx_mem[tx_addr_t'(i)] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    set_idling(19, 56);
    test_directed();
    test_rx_overflow();
    test_tx_overflow();
    test_random_mix(390);
    set_idling(56, 19);
    test_random_mix(390);
    set_idling(0, 0);
    test_random_mix(390);
    test_backpressure();

    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/uartrb_pkg.sv
hdl/uartrb_ram.sv
hdl/uart_rx_tx_ring_buffers_core.sv
tb/sv/testbench.sv
